@@ sv/gva_pkg.sv @@
// Shared types and constants of the gravity velocity accumulator.
package gva_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS  = 48;
  localparam int SQ_BITS   = 66;
  localparam int ROOT_BITS = 34;
  localparam int DIV_BITS  = 48;
  localparam int MUL_BITS  = 33;

  localparam logic [ACC_BITS-1:0] ACC_LIMIT   = '1;
  localparam logic [31:0]         GRAV_RESET  = 32'(1 << FRAC_BITS);
  localparam logic                ACT_LOAD    = 1'b0;
  localparam logic                ACT_APPLY   = 1'b1;
  localparam logic                REG_GRAV    = 1'b0;

  typedef struct packed {
    logic        action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_in_x;
    logic [31:0] vel_in_y;
    logic [31:0] vel_in_z;
    logic [30:0] body_radius;
    logic [31:0] other_mass;
    logic [31:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic        touching;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SKIP,
    KIND_APPLY
  } kind_t;

  // Queue entry: offsets for an apply, start velocity for a load
  typedef struct packed {
    kind_t       kind;
    logic [32:0] vx;
    logic [32:0] vy;
    logic [32:0] vz;
    logic [31:0] rsum;
    logic [31:0] mass;
    logic [31:0] dt;
  } entry_t;

  typedef struct packed {
    logic                start;
    logic [SQ_BITS-1:0]  rem0;
    logic [DIV_BITS-1:0] bits;
    logic [5:0]          nbits;
    logic [SQ_BITS-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_BITS-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/gva_front.sv @@
// Front end: accepts items, tracks the subject position and classifies each item.
module gva_front import gva_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_data
);

  logic [31:0] spx_r, spx_nxt, spy_r, spy_nxt, spz_r, spz_nxt;
  logic [30:0] srad_r, srad_nxt;
  logic [32:0] dx, dy, dz;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Offset to the subject and classification
  always_comb begin
    dx = {in_data.pos_x[31], in_data.pos_x} - {spx_r[31], spx_r};
    dy = {in_data.pos_y[31], in_data.pos_y} - {spy_r[31], spy_r};
    dz = {in_data.pos_z[31], in_data.pos_z} - {spz_r[31], spz_r};
    push_data = '0;
    if (in_data.action == ACT_LOAD) begin
      push_data.kind = KIND_LOAD;
      push_data.vx   = {in_data.vel_in_x[31], in_data.vel_in_x};
      push_data.vy   = {in_data.vel_in_y[31], in_data.vel_in_y};
      push_data.vz   = {in_data.vel_in_z[31], in_data.vel_in_z};
    end else begin
      push_data.kind = (dx == '0 && dy == '0 && dz == '0) ? KIND_SKIP : KIND_APPLY;
      push_data.vx   = dx;
      push_data.vy   = dy;
      push_data.vz   = dz;
      push_data.rsum = {1'b0, srad_r} + {1'b0, in_data.body_radius};
      push_data.mass = in_data.other_mass;
      push_data.dt   = in_data.time_step;
    end
  end

  // Replace the subject on a load
  always_comb begin
    spx_nxt  = spx_r;
    spy_nxt  = spy_r;
    spz_nxt  = spz_r;
    srad_nxt = srad_r;
    if (push && in_data.action == ACT_LOAD) begin
      spx_nxt  = in_data.pos_x;
      spy_nxt  = in_data.pos_y;
      spz_nxt  = in_data.pos_z;
      srad_nxt = in_data.body_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spx_r  <= '0;
      spy_r  <= '0;
      spz_r  <= '0;
      srad_r <= '0;
    end else begin
      spx_r  <= spx_nxt;
      spy_r  <= spy_nxt;
      spz_r  <= spz_nxt;
      srad_r <= srad_nxt;
    end
  end

endmodule

@@ sv/gva_fifo.sv @@
// Short queue of classified items between the front and back ends.
module gva_fifo import gva_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Advance pointers and count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

endmodule

@@ sv/gva_div.sv @@
// Restoring divider, one quotient bit per cycle.
module gva_div import gva_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SQ_BITS-1:0]  rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_BITS-1:0] bits_r, bits_nxt, quo_r, quo_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [SQ_BITS:0]    trial, diff;

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  // Shift in one numerator bit, subtract the divisor where it fits
  always_comb begin
    trial    = {rem_r, bits_r[DIV_BITS-1]};
    diff     = trial - {1'b0, den_r};
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem0;
      bits_nxt = req.bits;
      den_nxt  = req.den;
      cnt_nxt  = req.nbits;
      quo_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bits_nxt = {bits_r[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[SQ_BITS-1:0];
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SQ_BITS-1:0];
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

@@ sv/gva_back.sv @@
// Back end: sequencer that works one queued item through the shared units.
module gva_back import gva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  entry_t    q_data,
  output logic      pop,
  input  logic [31:0] grav,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_RR, ST_GM, ST_DIVA, ST_SQRT, ST_AV,
    ST_USTART, ST_DIVU, ST_MULU, ST_VEL, ST_DONE
  } state_t;

  localparam int HALF      = ACC_BITS / 2;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int PART_BITS = HALF + 32;
  localparam int FULL_BITS = ACC_BITS + 32;
  localparam int SRC_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int CAT_BITS  = REM_BITS + 2;
  localparam int DEL_BITS  = ACC_BITS + 1;
  localparam int SUM_BITS  = DEL_BITS + 2;
  localparam int U_BITS    = FRAC_BITS + 1;
  localparam int NUM_BITS  = 64 + FRAC_BITS;

  state_t               state_r, state_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [1:0]           ax_r, ax_nxt;
  logic [31:0]          vel_r [3];
  logic [31:0]          vel_nxt [3];
  logic [32:0]          mag_r [3];
  logic [32:0]          mag_nxt [3];
  logic [2:0]           neg_r, neg_nxt;
  logic [31:0]          rsum_r, rsum_nxt, mass_r, mass_nxt, dt_r, dt_nxt;
  logic [SQ_BITS-1:0]   s_r, s_nxt;
  logic [ACC_BITS-1:0]  acc_r, acc_nxt, v_r, v_nxt;
  logic [REM_BITS-1:0]  sq_rem_r, sq_rem_nxt;
  logic [ROOT_BITS-1:0] sq_root_r, sq_root_nxt;
  logic [SRC_BITS-1:0]  sq_src_r, sq_src_nxt;
  logic [PART_BITS-1:0] hi_r, hi_nxt;
  logic [U_BITS-1:0]    u_r, u_nxt;
  logic [DEL_BITS-1:0]  del_r, del_nxt;
  logic                 touch_r, touch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [PROD_BITS-1:0] prod_r;
  logic [MUL_BITS-1:0]  mul_a, mul_b;

  logic [CAT_BITS-1:0]  sq_cat, sq_diff;
  logic [CAT_BITS-1:0]  sq_trial;
  logic [NUM_BITS-1:0]  num_w;
  logic [NUM_BITS-ACC_BITS-1:0] num_hi;
  logic [FULL_BITS-1:0] full_w;
  logic [FULL_BITS-FRAC_BITS-1:0] av_shift;
  logic [SUM_BITS-1:0]  vel_ext, del_ext, vel_sum;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pick operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        if (ax_r == 2'd3) begin
          mul_a = MUL_BITS'(rsum_r);
          mul_b = MUL_BITS'(rsum_r);
        end else begin
          mul_a = mag_r[ax_r];
          mul_b = mag_r[ax_r];
        end
      end
      ST_RR: begin
        mul_a = MUL_BITS'(grav);
        mul_b = MUL_BITS'(mass_r);
      end
      ST_AV: begin
        mul_b = MUL_BITS'(dt_r);
        mul_a = (cnt_r == '0) ? MUL_BITS'(acc_r[ACC_BITS-1:HALF])
                              : MUL_BITS'(acc_r[HALF-1:0]);
      end
      ST_MULU: begin
        mul_b = MUL_BITS'(u_r);
        mul_a = (cnt_r == '0) ? MUL_BITS'(v_r[ACC_BITS-1:HALF])
                              : MUL_BITS'(v_r[HALF-1:0]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Datapath pieces used by several steps
  always_comb begin
    sq_cat   = {sq_rem_r, sq_src_r[SRC_BITS-1 -: 2]};
    sq_trial = CAT_BITS'({sq_root_r, 2'b01});
    sq_diff  = sq_cat - sq_trial;
    num_w    = {prod_r[63:0], {FRAC_BITS{1'b0}}};
    num_hi   = num_w[NUM_BITS-1:ACC_BITS];
    full_w   = {hi_r, {HALF{1'b0}}} + FULL_BITS'(prod_r[PART_BITS-1:0]);
    av_shift = full_w[FULL_BITS-1:FRAC_BITS];
    vel_ext  = {{(SUM_BITS-32){vel_r[ax_r][31]}}, vel_r[ax_r]};
    del_ext  = SUM_BITS'(del_r);
    vel_sum  = neg_r[ax_r] ? (vel_ext - del_ext) : (vel_ext + del_ext);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ax_nxt        = ax_r;
    vel_nxt       = vel_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rsum_nxt      = rsum_r;
    mass_nxt      = mass_r;
    dt_nxt        = dt_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    sq_rem_nxt    = sq_rem_r;
    sq_root_nxt   = sq_root_r;
    sq_src_nxt    = sq_src_r;
    hi_nxt        = hi_r;
    u_nxt         = u_r;
    del_nxt       = del_r;
    touch_nxt     = touch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    div_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          touch_nxt = 1'b0;
          case (q_data.kind)
            KIND_LOAD: begin
              vel_nxt[0] = q_data.vx[31:0];
              vel_nxt[1] = q_data.vy[31:0];
              vel_nxt[2] = q_data.vz[31:0];
              state_nxt  = ST_DONE;
            end
            KIND_APPLY: begin
              mag_nxt[0] = q_data.vx[32] ? (~q_data.vx + 33'd1) : q_data.vx;
              mag_nxt[1] = q_data.vy[32] ? (~q_data.vy + 33'd1) : q_data.vy;
              mag_nxt[2] = q_data.vz[32] ? (~q_data.vz + 33'd1) : q_data.vz;
              neg_nxt    = {q_data.vz[32], q_data.vy[32], q_data.vx[32]};
              rsum_nxt   = q_data.rsum;
              mass_nxt   = q_data.mass;
              dt_nxt     = q_data.dt;
              s_nxt      = '0;
              ax_nxt     = '0;
              state_nxt  = ST_SQ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      // Accumulate squared offsets, then issue the radius sum square
      ST_SQ: begin
        if (ax_r != 2'd0) begin
          s_nxt = s_r + prod_r;
        end
        ax_nxt = ax_r + 1'b1;
        if (ax_r == 2'd3) begin
          state_nxt = ST_RR;
        end
      end
      ST_RR: begin
        if (s_r <= prod_r) begin
          vel_nxt[0] = '0;
          vel_nxt[1] = '0;
          vel_nxt[2] = '0;
          touch_nxt  = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_GM;
        end
      end
      // Saturate or divide G*m by the squared distance
      ST_GM: begin
        if (SQ_BITS'(num_hi) >= s_r) begin
          acc_nxt     = ACC_LIMIT;
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          sq_src_nxt  = SRC_BITS'(s_r);
          cnt_nxt     = 6'(ROOT_BITS);
          state_nxt   = ST_SQRT;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = SQ_BITS'(num_hi);
          div_req.bits  = num_w[ACC_BITS-1:0];
          div_req.nbits = 6'(ACC_BITS);
          div_req.den   = s_r;
          state_nxt     = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (div_rsp.done) begin
          acc_nxt     = div_rsp.quo[ACC_BITS-1:0];
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          sq_src_nxt  = SRC_BITS'(s_r);
          cnt_nxt     = 6'(ROOT_BITS);
          state_nxt   = ST_SQRT;
        end
      end
      // One root bit per cycle
      ST_SQRT: begin
        sq_src_nxt = {sq_src_r[SRC_BITS-3:0], 2'b00};
        if (sq_cat >= sq_trial) begin
          sq_rem_nxt  = sq_diff[REM_BITS-1:0];
          sq_root_nxt = {sq_root_r[ROOT_BITS-2:0], 1'b1};
        end else begin
          sq_rem_nxt  = sq_cat[REM_BITS-1:0];
          sq_root_nxt = {sq_root_r[ROOT_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          cnt_nxt   = '0;
          state_nxt = ST_AV;
        end
      end
      // Velocity magnitude from two partial products
      ST_AV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd1) begin
          hi_nxt = prod_r[PART_BITS-1:0];
        end else if (cnt_r == 6'd2) begin
          v_nxt     = (av_shift[FULL_BITS-FRAC_BITS-1:ACC_BITS] != '0) ? ACC_LIMIT
                                                                      : av_shift[ACC_BITS-1:0];
          ax_nxt    = '0;
          state_nxt = ST_USTART;
        end
      end
      ST_USTART: begin
        div_req.start = 1'b1;
        div_req.rem0  = SQ_BITS'(mag_r[ax_r] >> 1);
        div_req.bits  = {mag_r[ax_r][0], {(DIV_BITS-1){1'b0}}};
        div_req.nbits = 6'(U_BITS);
        div_req.den   = SQ_BITS'(sq_root_r);
        state_nxt     = ST_DIVU;
      end
      ST_DIVU: begin
        if (div_rsp.done) begin
          u_nxt     = div_rsp.quo[U_BITS-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_MULU;
        end
      end
      ST_MULU: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd1) begin
          hi_nxt = prod_r[PART_BITS-1:0];
        end else if (cnt_r == 6'd2) begin
          del_nxt   = full_w[FRAC_BITS+DEL_BITS-1:FRAC_BITS];
          state_nxt = ST_VEL;
        end
      end
      // Add the signed delta and clamp to 32 bits
      ST_VEL: begin
        if (&vel_sum[SUM_BITS-1:31] || ~|vel_sum[SUM_BITS-1:31]) begin
          vel_nxt[ax_r] = vel_sum[31:0];
        end else begin
          vel_nxt[ax_r] = vel_sum[SUM_BITS-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        if (ax_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = ST_USTART;
        end
      end
      // Hold until the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.vel_x    = vel_r[0];
          out_data_nxt.vel_y    = vel_r[1];
          out_data_nxt.vel_z    = vel_r[2];
          out_data_nxt.touching = touch_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    rsum_r     <= rsum_nxt;
    mass_r     <= mass_nxt;
    dt_r       <= dt_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    v_r        <= v_nxt;
    sq_rem_r   <= sq_rem_nxt;
    sq_root_r  <= sq_root_nxt;
    sq_src_r   <= sq_src_nxt;
    hi_r       <= hi_nxt;
    u_r        <= u_nxt;
    del_r      <= del_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ax_r        <= '0;
      vel_r       <= '{default: '0};
      touch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ax_r        <= ax_nxt;
      vel_r       <= vel_nxt;
      touch_r     <= touch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_data_r.touching |->
      out_data_r.vel_x == '0 && out_data_r.vel_y == '0 && out_data_r.vel_z == '0)
    else $error("overlap result with nonzero velocity");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
      div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == ST_AV |-> sq_root_r != '0)
    else $error("zero distance after square root");

endmodule

@@ sv/gravity_velocity_accumulator.sv @@
// Gravity velocity accumulator: top level with the register port.
//
// Input channel (in_valid/in_ready/in_data): action 0 loads the subject body
// (position, velocity, radius); action 1 applies one other body (position,
// mass, radius, time step). Each item gives exactly one transaction on the
// output channel (out_valid/out_ready/out_data) with the velocity after it.
// Register port: one register, grav_constant, at byte address 0.
//
// A load or a coincident body needs no arithmetic, and an overlap ends after
// the distance check. An applied body takes a 48-bit restoring divide for the
// acceleration (skipped when it saturates), a 34-step square root, and a 17-bit
// divide per axis for the unit direction, all on one shared divider and one
// 33x33 multiplier. Items are handled one at a time by the back end, which takes
// the next queued item in the cycle after a result is registered.
// A short queue keeps the input side open meanwhile, so in_ready falls only
// when the queue is full.
// When the receiver stalls, the result holds in the output register and the
// back end waits with the next result; the queue keeps taking items until full.
// Reset clears the subject state to zero and sets grav_constant to 1.0.
module gravity_velocity_accumulator import gva_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] grav_r, grav_nxt;
  logic        push, pop, q_full, q_empty;
  entry_t      push_data, q_data;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GRAV) ? grav_r : '0;

  always_comb begin
    grav_nxt = grav_r;
    if (psel && penable && pwrite && paddr[2] == REG_GRAV) begin
      grav_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else begin
      grav_r <= grav_nxt;
    end
  end

  gva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  gva_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  gva_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gva_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .grav      (grav_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
